// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files of this block.
// Depends on nothing; every macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define AMU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define AMU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define AMU_ASSERT_NXT_ALL(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/adam_mu_pkg.sv =====
// Shared constants and types of the Adam moment update block.
// No dependencies; used by the top level, the moment RAM and the checker.
package adam_mu_pkg;

    localparam int VERTICES_DEF    = 512;
    localparam int COEFF_SLOTS_DEF = 8;

    // Stream payload layout, lowest bit first.
    localparam int VERT_W   = 9;
    localparam int SLOT_W   = 3;
    localparam int GRAD_W   = 32;
    localparam int MOM_W    = 32;
    localparam int VERT_LSB = 0;
    localparam int SLOT_LSB = VERT_LSB + VERT_W;
    localparam int GRAD_LSB = SLOT_LSB + SLOT_W;
    localparam int TDATA_W  = 48;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEARNING_RATE = 3'd0,
        REG_FIRST_DECAY   = 3'd1,
        REG_SECOND_DECAY  = 3'd2,
        REG_STABILIZER    = 3'd3,
        REG_STEP_NUMBER   = 3'd4
    } cfg_reg_t;

    localparam logic [23:0] LR_RESET    = 24'd16777;
    localparam logic [15:0] B1_RESET    = 16'd58982;
    localparam logic [15:0] B2_RESET    = 16'd65470;
    localparam logic [23:0] EPS_RESET   = 24'd1;
    localparam logic [15:0] STEP_RESET  = 16'd1;

    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

endpackage

// ===== rtl/adam_moment_update.sv =====
// Adam moment update: one gradient in, one saturated coefficient increment out.
// A new request is taken every cycle while the block streams and the output is not
// stalled; the dividers and root unit are fully pipelined.
// Synchronous active-low reset; then a clearing pass over all VERTICES*COEFF_SLOTS
// entries zeroes both moment RAMs, and the bias corrections are computed after it.
// A configuration write after clearing restarts the correction step; input waits.
module adam_moment_update #(
    parameter int VERTICES    = adam_mu_pkg::VERTICES_DEF,
    parameter int COEFF_SLOTS = adam_mu_pkg::COEFF_SLOTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input requests.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: vertex_index[8:0], coeff_slot[11:9], gradient[43:12], zero[47:44]
    input  logic [adam_mu_pkg::TDATA_W-1:0]     s_tdata,
    // Result requests.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: out_vertex_index[8:0], out_coeff_slot[11:9],
    //          coeff_increment[43:12], zero[47:44]
    output logic [adam_mu_pkg::TDATA_W-1:0]     m_tdata,
    // Configuration writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [adam_mu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [adam_mu_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int DEPTH      = VERTICES * COEFF_SLOTS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam int DIV1_STEPS = 64;
    localparam int ROOT_STEPS = 32;
    localparam int DIV2_STEPS = 32;
    localparam logic [5:0] SEQ_LAST = 6'd33;

    // The block is either clearing the moment RAMs, computing the bias
    // corrections, or streaming.
    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_CORR  = 3'b010,
        ST_RUN   = 3'b100
    } state_t;

    // Per-request tag that rides along the pipeline.
    typedef struct packed {
        logic [adam_mu_pkg::VERT_W-1:0] vert;
        logic [adam_mu_pkg::SLOT_W-1:0] slot;
        logic                           in_range;
        logic                           neg;
    } tag_t;

    // Rounded Q0.32 product used by the power sequencer.
    function automatic logic [32:0] q32_mul(input logic [32:0] a, input logic [31:0] b);
        logic [64:0] p;
        p = {32'b0, a} * {33'b0, b} + 65'h0_8000_0000;
        return p[64:32];
    endfunction

    //----------------------------------------------------------------------
    // Configuration registers. Writes are always taken.
    //----------------------------------------------------------------------
    logic [23:0] lr_reg;
    logic [15:0] b1_reg;
    logic [15:0] b2_reg;
    logic [23:0] eps_reg;
    logic [15:0] step_reg;
    logic        cfg_accept;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid & cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lr_reg   <= adam_mu_pkg::LR_RESET;
            b1_reg   <= adam_mu_pkg::B1_RESET;
            b2_reg   <= adam_mu_pkg::B2_RESET;
            eps_reg  <= adam_mu_pkg::EPS_RESET;
            step_reg <= adam_mu_pkg::STEP_RESET;
        end else if (cfg_accept) begin
            case (cfg_index)
                adam_mu_pkg::REG_LEARNING_RATE: lr_reg   <= cfg_data;
                adam_mu_pkg::REG_FIRST_DECAY:   b1_reg   <= cfg_data[15:0];
                adam_mu_pkg::REG_SECOND_DECAY:  b2_reg   <= cfg_data[15:0];
                adam_mu_pkg::REG_STABILIZER:    eps_reg  <= cfg_data;
                adam_mu_pkg::REG_STEP_NUMBER:   step_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    //----------------------------------------------------------------------
    // Control sequencer: clearing pass, then the bias-correction powers.
    // The powers beta^t are formed square-and-multiply, LSB first: in each
    // bit position the accumulator is multiplied when the bit is set (odd
    // count), then the base is squared (even count).
    //----------------------------------------------------------------------
    state_t              state_reg;
    logic [ADDR_W-1:0]   clr_addr_reg;
    logic [5:0]          seq_cnt_reg;
    logic [15:0]         t_reg;
    logic [32:0]         acc1_reg, acc2_reg;
    logic [31:0]         base1_reg, base2_reg;
    logic [32:0]         corr1_reg, corr2_reg;
    logic [32:0]         base1_sq, base2_sq;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            seq_cnt_reg  <= '0;
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == LAST_ADDR) begin
                        state_reg   <= ST_CORR;
                        seq_cnt_reg <= '0;
                    end
                end
                ST_CORR: begin
                    if (cfg_accept) begin
                        seq_cnt_reg <= '0;
                    end else if (seq_cnt_reg == SEQ_LAST) begin
                        state_reg <= ST_RUN;
                    end else begin
                        seq_cnt_reg <= seq_cnt_reg + 1'b1;
                    end
                end
                ST_RUN: begin
                    if (cfg_accept) begin
                        state_reg   <= ST_CORR;
                        seq_cnt_reg <= '0;
                    end
                end
                default: state_reg <= ST_CLEAR;
            endcase
        end
    end

    assign base1_sq = q32_mul({1'b0, base1_reg}, base1_reg);
    assign base2_sq = q32_mul({1'b0, base2_reg}, base2_reg);

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CORR) begin
            if (seq_cnt_reg == '0) begin
                acc1_reg  <= adam_mu_pkg::ONE_Q32;
                acc2_reg  <= adam_mu_pkg::ONE_Q32;
                base1_reg <= {b1_reg, 16'b0};
                base2_reg <= {b2_reg, 16'b0};
                // A step number of zero counts as one.
                t_reg     <= (step_reg == '0) ? 16'd1 : step_reg;
            end else if (seq_cnt_reg == SEQ_LAST) begin
                corr1_reg <= adam_mu_pkg::ONE_Q32 - acc1_reg;
                corr2_reg <= adam_mu_pkg::ONE_Q32 - acc2_reg;
            end else if (seq_cnt_reg[0]) begin
                if (t_reg[0]) begin
                    acc1_reg <= q32_mul(acc1_reg, base1_reg);
                    acc2_reg <= q32_mul(acc2_reg, base2_reg);
                end
            end else begin
                base1_reg <= base1_sq[31:0];
                base2_reg <= base2_sq[31:0];
                t_reg     <= {1'b0, t_reg[15:1]};
            end
        end
    end

    //----------------------------------------------------------------------
    // Pipeline advance. The whole pipeline moves unless a finished result
    // sits in the last stage while the output register is full and stalled,
    // so requests keep entering while a result waits, until the last stage fills.
    //----------------------------------------------------------------------
    logic adv;
    logic in_accept;
    logic q_last_valid;
    logic m_tvalid_reg;

    assign adv       = !(q_last_valid && m_tvalid_reg && !m_tready);
    assign s_tready  = adv && (state_reg == ST_RUN);
    assign in_accept = s_tvalid && s_tready;

    //----------------------------------------------------------------------
    // Stage 0: capture the request, square the gradient and form the
    // gradient term of the first moment. The RAM read is issued from here.
    //----------------------------------------------------------------------
    logic [adam_mu_pkg::VERT_W-1:0] in_vert;
    logic [adam_mu_pkg::SLOT_W-1:0] in_slot;
    logic signed [31:0]             in_grad;
    logic [31:0]                    in_gmag;
    logic [31:0]                    in_entry;
    logic                           in_range;
    logic [16:0]                    omb1, omb2;

    assign in_vert  = s_tdata[adam_mu_pkg::VERT_LSB +: adam_mu_pkg::VERT_W];
    assign in_slot  = s_tdata[adam_mu_pkg::SLOT_LSB +: adam_mu_pkg::SLOT_W];
    assign in_grad  = $signed(s_tdata[adam_mu_pkg::GRAD_LSB +: adam_mu_pkg::GRAD_W]);
    assign in_gmag  = in_grad[31] ? 32'(-in_grad) : in_grad;
    assign in_entry = 32'(in_vert) * 32'(COEFF_SLOTS) + 32'(in_slot);
    assign in_range = (32'(in_vert) < 32'(VERTICES)) && (32'(in_slot) < 32'(COEFF_SLOTS));
    assign omb1     = 17'h1_0000 - {1'b0, b1_reg};
    assign omb2     = 17'h1_0000 - {1'b0, b2_reg};

    logic               r0_valid_reg;
    tag_t               r0_tag_reg;
    logic [ADDR_W-1:0]  r0_addr_reg;
    logic [63:0]        r0_gsq_reg;
    logic signed [49:0] r0_gt1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r0_valid_reg <= 1'b0;
        end else if (adv) begin
            r0_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r0_tag_reg  <= '{vert: in_vert, slot: in_slot, in_range: in_range, neg: 1'b0};
            r0_addr_reg <= in_entry[ADDR_W-1:0];
            r0_gsq_reg  <= in_gmag * in_gmag;
            r0_gt1_reg  <= $signed({1'b0, omb1}) * in_grad;
        end
    end

    //----------------------------------------------------------------------
    // Moment RAMs. During the clearing pass both are written with zero.
    //----------------------------------------------------------------------
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [31:0]       m_wdata, v_wdata;
    logic [31:0]       m_rdata, v_rdata;
    logic [31:0]       m_new, v_new;
    logic              r1_valid_reg;
    tag_t              r1_tag_reg;
    logic [ADDR_W-1:0] r1_addr_reg;

    assign ram_we    = (state_reg == ST_CLEAR) ||
                       (adv && r1_valid_reg && r1_tag_reg.in_range);
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : r1_addr_reg;
    assign m_wdata   = (state_reg == ST_CLEAR) ? '0 : m_new;
    assign v_wdata   = (state_reg == ST_CLEAR) ? '0 : v_new;

    adam_mu_ram #(
        .WIDTH (adam_mu_pkg::MOM_W),
        .DEPTH (DEPTH)
    ) u_first_moment (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (m_wdata),
        .re    (adv),
        .raddr (r0_addr_reg),
        .rdata (m_rdata)
    );

    adam_mu_ram #(
        .WIDTH (adam_mu_pkg::MOM_W),
        .DEPTH (DEPTH)
    ) u_second_moment (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (v_wdata),
        .re    (adv),
        .raddr (r0_addr_reg),
        .rdata (v_rdata)
    );

    //----------------------------------------------------------------------
    // Stage 1: read-modify-write. The RAM returns the value from before a
    // write to the same entry in the cycle of the read, so a request directly
    // behind one that updates the same entry takes the update from the
    // forwarding registers instead.
    //----------------------------------------------------------------------
    logic               fwd_reg;
    logic [31:0]        fwd_m_reg, fwd_v_reg;
    logic signed [49:0] r1_gt1_reg;
    logic [48:0]        r1_gt2_reg;
    logic [31:0]        g2_sat;

    assign g2_sat = (|r0_gsq_reg[63:56]) ? 32'hFFFF_FFFF : r0_gsq_reg[55:24];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else if (adv) begin
            r1_valid_reg <= r0_valid_reg;
            fwd_reg      <= r0_valid_reg && r1_valid_reg && r1_tag_reg.in_range &&
                            (r0_addr_reg == r1_addr_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r1_tag_reg  <= r0_tag_reg;
            r1_addr_reg <= r0_addr_reg;
            r1_gt1_reg  <= r0_gt1_reg;
            r1_gt2_reg  <= omb2 * g2_sat;
            fwd_m_reg   <= m_new;
            fwd_v_reg   <= v_new;
        end
    end

    logic signed [31:0] m_old;
    logic [31:0]        v_old;
    logic signed [48:0] m_prod;
    logic signed [51:0] m_sum;
    logic [47:0]        v_prod;
    logic [50:0]        v_sum;

    assign m_old  = $signed(fwd_reg ? fwd_m_reg : m_rdata);
    assign v_old  = fwd_reg ? fwd_v_reg : v_rdata;
    assign m_prod = $signed({1'b0, b1_reg}) * m_old;
    assign m_sum  = 52'(m_prod) + 52'(r1_gt1_reg) + 52'sd32768;
    assign v_prod = b2_reg * v_old;
    assign v_sum  = 51'(v_prod) + 51'(r1_gt2_reg) + 51'd32768;

    // Floor of the sum over 2^16, saturated to the moment formats.
    always_comb begin
        if ((m_sum[51:47] == 5'b00000) || (m_sum[51:47] == 5'b11111)) begin
            m_new = m_sum[47:16];
        end else if (m_sum[51]) begin
            m_new = 32'h8000_0000;
        end else begin
            m_new = 32'h7FFF_FFFF;
        end
        v_new = (|v_sum[50:48]) ? 32'hFFFF_FFFF : v_sum[47:16];
    end

    //----------------------------------------------------------------------
    // Stage 2: updated moments, ready for the bias-correction dividers.
    //----------------------------------------------------------------------
    logic        r2_valid_reg;
    tag_t        r2_tag_reg;
    logic [31:0] r2_m_reg, r2_v_reg;
    logic [31:0] r2_mmag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r2_valid_reg <= 1'b0;
        end else if (adv) begin
            r2_valid_reg <= r1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r2_tag_reg <= '{vert: r1_tag_reg.vert, slot: r1_tag_reg.slot,
                            in_range: r1_tag_reg.in_range, neg: m_new[31]};
            r2_m_reg   <= m_new;
            r2_v_reg   <= v_new;
        end
    end

    assign r2_mmag = r2_m_reg[31] ? 32'(-$signed(r2_m_reg)) : r2_m_reg;

    //----------------------------------------------------------------------
    // Bias-correction dividers, one quotient bit per stage, both running side
    // by side: mhat = (|m| << 32) / corr1 and vhat = (v << 32) / corr2.
    //----------------------------------------------------------------------
    logic        d_valid_reg [0:DIV1_STEPS];
    tag_t        d_tag_reg   [0:DIV1_STEPS];
    logic [32:0] d1_rem_reg  [0:DIV1_STEPS];
    logic [63:0] d1_nq_reg   [0:DIV1_STEPS];
    logic [32:0] d2_rem_reg  [0:DIV1_STEPS];
    logic [63:0] d2_nq_reg   [0:DIV1_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg[0] <= 1'b0;
        end else if (adv) begin
            d_valid_reg[0] <= r2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_tag_reg[0]  <= r2_tag_reg;
            d1_rem_reg[0] <= '0;
            d1_nq_reg[0]  <= {r2_mmag, 32'b0};
            d2_rem_reg[0] <= '0;
            d2_nq_reg[0]  <= {r2_v_reg, 32'b0};
        end
    end

    for (genvar k = 0; k < DIV1_STEPS; k++) begin : g_div1
        logic [33:0] try1, try2;
        logic        ge1, ge2;

        assign try1 = {d1_rem_reg[k], d1_nq_reg[k][63]};
        assign try2 = {d2_rem_reg[k], d2_nq_reg[k][63]};
        assign ge1  = try1 >= {1'b0, corr1_reg};
        assign ge2  = try2 >= {1'b0, corr2_reg};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                d_valid_reg[k+1] <= 1'b0;
            end else if (adv) begin
                d_valid_reg[k+1] <= d_valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                d_tag_reg[k+1]  <= d_tag_reg[k];
                d1_rem_reg[k+1] <= ge1 ? 33'(try1 - {1'b0, corr1_reg}) : try1[32:0];
                d1_nq_reg[k+1]  <= {d1_nq_reg[k][62:0], ge1};
                d2_rem_reg[k+1] <= ge2 ? 33'(try2 - {1'b0, corr2_reg}) : try2[32:0];
                d2_nq_reg[k+1]  <= {d2_nq_reg[k][62:0], ge2};
            end
        end
    end

    //----------------------------------------------------------------------
    // Square root of vhat << 16 (kept to 64 bits), two radicand bits per
    // stage. The corrected first moment travels alongside.
    //----------------------------------------------------------------------
    logic        s_valid_reg [0:ROOT_STEPS];
    tag_t        s_tag_reg   [0:ROOT_STEPS];
    logic [33:0] s_rem_reg   [0:ROOT_STEPS];
    logic [31:0] s_root_reg  [0:ROOT_STEPS];
    logic [63:0] s_x_reg     [0:ROOT_STEPS];
    logic [63:0] s_bigm_reg  [0:ROOT_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_valid_reg[0] <= 1'b0;
        end else if (adv) begin
            s_valid_reg[0] <= d_valid_reg[DIV1_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s_tag_reg[0]  <= d_tag_reg[DIV1_STEPS];
            s_rem_reg[0]  <= '0;
            s_root_reg[0] <= '0;
            s_x_reg[0]    <= {d2_nq_reg[DIV1_STEPS][47:0], 16'b0};
            s_bigm_reg[0] <= d1_nq_reg[DIV1_STEPS];
        end
    end

    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
        logic [35:0] cur;
        logic [35:0] trial;
        logic        ge;

        assign cur   = {s_rem_reg[k], s_x_reg[k][63:62]};
        assign trial = {2'b0, s_root_reg[k], 2'b01};
        assign ge    = cur >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                s_valid_reg[k+1] <= 1'b0;
            end else if (adv) begin
                s_valid_reg[k+1] <= s_valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                s_tag_reg[k+1]  <= s_tag_reg[k];
                s_rem_reg[k+1]  <= ge ? 34'(cur - trial) : cur[33:0];
                s_root_reg[k+1] <= {s_root_reg[k][30:0], ge};
                s_x_reg[k+1]    <= {s_x_reg[k][61:0], 2'b00};
                s_bigm_reg[k+1] <= s_bigm_reg[k];
            end
        end
    end

    //----------------------------------------------------------------------
    // Denominator and the scaled numerator lr * mhat, split into two
    // 24 x 32 partial products and summed one stage later.
    //----------------------------------------------------------------------
    logic        p0_valid_reg;
    tag_t        p0_tag_reg;
    logic [36:0] p0_den_reg;
    logic [55:0] p0_lo_reg, p0_hi_reg;
    logic        p0_bignz_reg;
    logic [63:0] root_bigm;

    assign root_bigm = s_bigm_reg[ROOT_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_valid_reg <= 1'b0;
        end else if (adv) begin
            p0_valid_reg <= s_valid_reg[ROOT_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p0_tag_reg   <= s_tag_reg[ROOT_STEPS];
            p0_den_reg   <= 37'({s_root_reg[ROOT_STEPS], 4'b0}) + 37'(eps_reg);
            p0_lo_reg    <= lr_reg * root_bigm[31:0];
            p0_hi_reg    <= lr_reg * root_bigm[63:32];
            p0_bignz_reg <= |root_bigm;
        end
    end

    logic        p1_valid_reg;
    tag_t        p1_tag_reg;
    logic [36:0] p1_den_reg;
    logic [87:0] p1_num_reg;
    logic        p1_bignz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (adv) begin
            p1_valid_reg <= p0_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_tag_reg   <= p0_tag_reg;
            p1_den_reg   <= p0_den_reg;
            p1_num_reg   <= 88'(p0_lo_reg) + {p0_hi_reg, 32'b0};
            p1_bignz_reg <= p0_bignz_reg;
        end
    end

    //----------------------------------------------------------------------
    // Final divider. When the upper numerator bits already reach the
    // denominator the quotient is at least 2^32 and saturates; otherwise
    // 32 more quotient bits are formed, one per stage.
    //----------------------------------------------------------------------
    logic        q_valid_reg [0:DIV2_STEPS];
    tag_t        q_tag_reg   [0:DIV2_STEPS];
    logic [36:0] q_den_reg   [0:DIV2_STEPS];
    logic [36:0] q_rem_reg   [0:DIV2_STEPS];
    logic [31:0] q_nq_reg    [0:DIV2_STEPS];
    logic        q_sat_reg   [0:DIV2_STEPS];
    logic        q_den0_reg  [0:DIV2_STEPS];
    logic        q_bignz_reg [0:DIV2_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_valid_reg[0] <= 1'b0;
        end else if (adv) begin
            q_valid_reg[0] <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            q_tag_reg[0]   <= p1_tag_reg;
            q_den_reg[0]   <= p1_den_reg;
            q_rem_reg[0]   <= p1_num_reg[68:32];
            q_nq_reg[0]    <= p1_num_reg[31:0];
            q_sat_reg[0]   <= p1_num_reg[87:32] >= 56'(p1_den_reg);
            q_den0_reg[0]  <= (p1_den_reg == '0);
            q_bignz_reg[0] <= p1_bignz_reg;
        end
    end

    for (genvar k = 0; k < DIV2_STEPS; k++) begin : g_div2
        logic [37:0] cur;
        logic        ge;

        assign cur = {q_rem_reg[k], q_nq_reg[k][31]};
        assign ge  = cur >= {1'b0, q_den_reg[k]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                q_valid_reg[k+1] <= 1'b0;
            end else if (adv) begin
                q_valid_reg[k+1] <= q_valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                q_tag_reg[k+1]   <= q_tag_reg[k];
                q_den_reg[k+1]   <= q_den_reg[k];
                q_rem_reg[k+1]   <= ge ? 37'(cur - {1'b0, q_den_reg[k]}) : cur[36:0];
                q_nq_reg[k+1]    <= {q_nq_reg[k][30:0], ge};
                q_sat_reg[k+1]   <= q_sat_reg[k];
                q_den0_reg[k+1]  <= q_den0_reg[k];
                q_bignz_reg[k+1] <= q_bignz_reg[k];
            end
        end
    end

    assign q_last_valid = q_valid_reg[DIV2_STEPS];

    //----------------------------------------------------------------------
    // Saturation, sign and the output register.
    //----------------------------------------------------------------------
    tag_t        fin_tag;
    logic [31:0] fin_limit;
    logic [31:0] fin_mag;
    logic [31:0] fin_inc;
    logic [31:0] fin_q;

    assign fin_tag   = q_tag_reg[DIV2_STEPS];
    assign fin_q     = q_nq_reg[DIV2_STEPS];
    assign fin_limit = fin_tag.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;

    always_comb begin
        if (q_den0_reg[DIV2_STEPS]) begin
            // Zero denominator: zero for a zero moment, else full scale.
            fin_mag = q_bignz_reg[DIV2_STEPS] ? fin_limit : '0;
        end else if (q_sat_reg[DIV2_STEPS] || (fin_q > fin_limit)) begin
            fin_mag = fin_limit;
        end else begin
            fin_mag = fin_q;
        end
        if (!fin_tag.in_range) begin
            fin_inc = '0;
        end else if (fin_tag.neg) begin
            fin_inc = 32'(-fin_mag);
        end else begin
            fin_inc = fin_mag;
        end
    end

    logic [adam_mu_pkg::TDATA_W-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (q_last_valid && adv) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_last_valid && adv) begin
            m_tdata_reg <= {4'b0, fin_inc, fin_tag.slot, fin_tag.vert};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/adam_mu_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// Uses adam_mu_pkg defaults; instantiated for the first and second moment stores.
module adam_mu_ram #(
    parameter int WIDTH = adam_mu_pkg::MOM_W,
    parameter int DEPTH = adam_mu_pkg::VERTICES_DEF * adam_mu_pkg::COEFF_SLOTS_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // A read of the address being written returns the old contents.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/adam_mu_checker.sv =====
// Port-level checker for the Adam moment update block, bound to its top level.
// Depends on adam_mu_pkg and the assertion macros in assert_macros.svh.
`include "assert_macros.svh"

module adam_mu_checker #(
    parameter int COEFF_SLOTS = adam_mu_pkg::COEFF_SLOTS_DEF
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [adam_mu_pkg::TDATA_W-1:0] m_tdata,
    input logic                            cfg_valid,
    input logic                            cfg_ready
);

    logic [31:0] out_slot;
    logic [31:0] out_inc;

    assign out_slot = 32'(m_tdata[adam_mu_pkg::SLOT_LSB +: adam_mu_pkg::SLOT_W]);
    assign out_inc  = m_tdata[adam_mu_pkg::GRAD_LSB +: adam_mu_pkg::GRAD_W];

    // A stalled result holds.
    `AMU_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // The clearing pass keeps input closed right after reset.
    `AMU_ASSERT_NXT_ALL(a_reset_closes_input, aclk, !aresetn, !s_tready)

    // A configuration write starts the correction step, which closes input.
    `AMU_ASSERT_NXT(a_cfg_closes_input, aclk, aresetn, cfg_valid && cfg_ready, !s_tready)

    // A slot outside the store yields a zero increment.
    `AMU_ASSERT_IMP(a_bad_slot_zero, aclk, aresetn, m_tvalid && (out_slot >= 32'(COEFF_SLOTS)), out_inc == '0)

endmodule

bind adam_moment_update adam_mu_checker #(
    .COEFF_SLOTS (COEFF_SLOTS)
) u_adam_mu_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
